FILE: sv/fpw_pkg.sv
// Package for the four-level page table walker.
// Holds the classified command and result types, kind codes and helpers.
// No dependencies; every file in sv/ but fpw_if.sv imports it.
package fpw_pkg;

  localparam int VA_W    = 48;
  localparam int PA_W    = 52;
  localparam int ENTRY_W = 64;
  localparam int LEVEL_W = 2;
  localparam int IDX_W   = 9;

  // Request types on the input channel
  localparam logic REQ_TRANSLATE = 1'b0;
  localparam logic REQ_RESPONSE  = 1'b1;

  // Result kinds
  localparam logic [1:0] KIND_READ = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_PERR = 2'd2;

  // Page sizes
  localparam logic [1:0] PSZ_4K = 2'd0;
  localparam logic [1:0] PSZ_2M = 2'd1;
  localparam logic [1:0] PSZ_1G = 2'd2;

  // Walk levels
  localparam logic [LEVEL_W-1:0] LVL_TOP  = 2'd0;
  localparam logic [LEVEL_W-1:0] LVL_1G   = 2'd1;
  localparam logic [LEVEL_W-1:0] LVL_2M   = 2'd2;
  localparam logic [LEVEL_W-1:0] LVL_LEAF = 2'd3;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [ENTRY_W-1:0] BIT_PRESENT = 64'h1;
  localparam logic [ENTRY_W-1:0] BIT_PS      = 64'h80;

  // One classified transaction, as the front hands it to the back
  typedef struct packed {
    logic            is_resp;
    logic            fail;     // read error or entry not present
    logic            ps;       // page-size bit of the entry
    logic [PA_W-1:0] frame;    // 4KB-aligned frame, masked to PA_BITS
    logic [VA_W-1:0] vaddr;
  } fpw_cmd_t;

  typedef struct packed {
    logic [1:0]         out_kind;
    logic [PA_W-1:0]    read_addr;
    logic [PA_W-1:0]    phys_addr;
    logic               fault;
    logic [LEVEL_W-1:0] fault_level;
    logic [1:0]         map_size;
  } fpw_res_t;

  // Table index of a virtual address at a given level
  function automatic logic [IDX_W-1:0] va_index(input logic [VA_W-1:0] va,
                                                input logic [LEVEL_W-1:0] lvl);
    logic [IDX_W-1:0] idx;
    unique case (lvl)
      LVL_TOP: idx = va[47:39];
      LVL_1G:  idx = va[38:30];
      LVL_2M:  idx = va[29:21];
      default: idx = va[20:12];
    endcase
    return idx;
  endfunction

  // Entry address: table base plus index times 8
  function automatic logic [PA_W-1:0] entry_addr(input logic [PA_W-1:0] tbl,
                                                 input logic [VA_W-1:0] va,
                                                 input logic [LEVEL_W-1:0] lvl);
    return tbl + {{(PA_W-IDX_W-3){1'b0}}, va_index(va, lvl), 3'b000};
  endfunction

endpackage

FILE: sv/fpw_if.sv
// Valid/ready channel interfaces for the page table walker.
// fpw_in_if carries requests and entry responses, fpw_out_if carries results.
// No dependencies.
interface fpw_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [51:0] dir_base;
  logic [47:0] virt_addr;
  logic [63:0] entry_data;
  logic        read_error;

  modport source(output valid, req_type, dir_base, virt_addr, entry_data, read_error,
                 input ready);
  modport sink(input valid, req_type, dir_base, virt_addr, entry_data, read_error,
               output ready);
endinterface

interface fpw_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  out_kind;
  logic [51:0] read_addr;
  logic [51:0] phys_addr;
  logic        fault;
  logic [1:0]  fault_level;
  logic [1:0]  map_size;

  modport source(output valid, out_kind, read_addr, phys_addr, fault, fault_level,
                 map_size, input ready);
  modport sink(input valid, out_kind, read_addr, phys_addr, fault, fault_level,
               map_size, output ready);
endinterface

FILE: sv/fpw_front.sv
// Front end of the page table walker: classifies input transactions.
// Masks frames to PA_BITS and decodes entry flags. Depends on fpw_pkg.
module fpw_front #(
  parameter int PA_BITS = 52
) (
  input  logic             req_type,
  input  logic [51:0]      dir_base,
  input  logic [47:0]      virt_addr,
  input  logic [63:0]      entry_data,
  input  logic             read_error,
  output fpw_pkg::fpw_cmd_t cmd
);
  import fpw_pkg::*;

  localparam logic [PA_W-1:0] PA_MASK  = {PA_W{1'b1}} >> (PA_W - PA_BITS);
  localparam logic [PA_W-1:0] FRAME_4K = PA_MASK & ~52'hfff;

  logic [PA_W-1:0] src;

  assign src = (req_type == REQ_RESPONSE) ? entry_data[PA_W-1:0] : dir_base;

  always_comb begin
    cmd.is_resp = (req_type == REQ_RESPONSE);
    cmd.fail    = read_error || ((entry_data & BIT_PRESENT) == '0);
    cmd.ps      = ((entry_data & BIT_PS) != '0);
    cmd.frame   = src & FRAME_4K;
    cmd.vaddr   = virt_addr;
  end

endmodule

FILE: sv/fpw_queue.sv
// Short FIFO between the front and back of the page table walker.
// Stores classified commands. Depends on fpw_pkg.
module fpw_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  fpw_pkg::fpw_cmd_t push_data,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output fpw_pkg::fpw_cmd_t pop_data
);
  import fpw_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_C  = PTR_W'(QUEUE_DEPTH - 1);

  fpw_cmd_t         slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full      = (count_r == DEPTH_C);
  assign not_empty = (count_r != '0);
  assign pop_data  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_C) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_C) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: sv/fpw_back.sv
// Back end of the page table walker: holds the walk state and forms results.
// One command per cycle, while the result is not stalled, into a registered result. Depends on fpw_pkg.
module fpw_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_valid,
  input  fpw_pkg::fpw_cmd_t cmd,
  output logic              cmd_pop,
  output logic              res_valid,
  input  logic              res_ready,
  output fpw_pkg::fpw_res_t res
);
  import fpw_pkg::*;

  logic               busy_r, busy_nxt;
  logic [LEVEL_W-1:0] level_r, level_nxt;
  logic [VA_W-1:0]    vaddr_r, vaddr_nxt;
  logic               res_valid_r;
  fpw_res_t           res_r, res_nxt;
  logic [PA_W-1:0]    frame_2m, frame_1g;
  logic [LEVEL_W-1:0] level_inc;

  assign cmd_pop   = cmd_valid && (!res_valid_r || res_ready);
  assign res_valid = res_valid_r;
  assign res       = res_r;
  assign frame_2m  = cmd.frame & ~52'h1fffff;
  assign frame_1g  = cmd.frame & ~52'h3fffffff;
  assign level_inc = level_r + 1'b1;

  always_comb begin
    busy_nxt  = busy_r;
    level_nxt = level_r;
    vaddr_nxt = vaddr_r;
    res_nxt   = '{out_kind: KIND_PERR, read_addr: '0, phys_addr: '0, fault: 1'b0,
                  fault_level: LVL_TOP, map_size: PSZ_4K};
    if (!cmd.is_resp) begin
      if (!busy_r) begin
        // start a walk at the top table
        busy_nxt          = 1'b1;
        level_nxt         = LVL_TOP;
        vaddr_nxt         = cmd.vaddr;
        res_nxt.out_kind  = KIND_READ;
        res_nxt.read_addr = entry_addr(cmd.frame, cmd.vaddr, LVL_TOP);
      end
    end else if (busy_r) begin
      res_nxt.out_kind    = KIND_DONE;
      res_nxt.fault_level = level_r;
      busy_nxt            = 1'b0;
      level_nxt           = LVL_TOP;
      if (cmd.fail) begin
        res_nxt.fault = 1'b1;
      end else if (level_r == LVL_1G && cmd.ps) begin
        res_nxt.phys_addr = frame_1g | {22'b0, vaddr_r[29:0]};
        res_nxt.map_size  = PSZ_1G;
      end else if (level_r == LVL_2M && cmd.ps) begin
        res_nxt.phys_addr = frame_2m | {31'b0, vaddr_r[20:0]};
        res_nxt.map_size  = PSZ_2M;
      end else if (level_r == LVL_LEAF) begin
        if (cmd.frame == '0) begin
          res_nxt.fault = 1'b1;
        end else begin
          res_nxt.phys_addr = cmd.frame | {40'b0, vaddr_r[11:0]};
        end
      end else begin
        // descend to the next table
        busy_nxt            = 1'b1;
        level_nxt           = level_inc;
        res_nxt.out_kind    = KIND_READ;
        res_nxt.fault_level = level_inc;
        res_nxt.read_addr   = entry_addr(cmd.frame, vaddr_r, level_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      level_r     <= LVL_TOP;
      vaddr_r     <= '0;
      res_valid_r <= 1'b0;
    end else begin
      if (cmd_pop) begin
        busy_r  <= busy_nxt;
        level_r <= level_nxt;
        vaddr_r <= vaddr_nxt;
      end
      if (cmd_pop) begin
        res_valid_r <= 1'b1;
      end else if (res_ready) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      res_r <= res_nxt;
    end
  end

endmodule

FILE: sv/four_level_page_table_walker_core.sv
// Four-level x86-64 page table walker, top level.
// Instantiates fpw_front, fpw_queue and fpw_back; depends on fpw_pkg and fpw_if.
//
// Usage: in_chan carries two kinds of transaction. A translate request
// (req_type 0) gives the top table base and a 48-bit virtual address; an
// entry response (req_type 1) returns the entry that memory read for the last
// read request, with a read error flag. out_chan carries exactly one result
// per input transaction: a read request for the next entry, a finished
// translation (physical address or fault and the level where the walk ended),
// or a protocol error for a request while a walk runs or a response while idle.
// Order: a transaction enters the front queue at the accepting edge, and the
// back registers its result once it takes the transaction from the queue.
// Throughput is one transaction per cycle when nothing stalls, set by the
// walk step in the back (masks and one 52-bit add).
// Stalls: when out_chan is not ready, hold the result register; the two-entry
// queue keeps accepting until full, then in_chan.ready drops.
// Reset: synchronous active-low rst_n empties the queue, drops the result and
// returns the walker to idle at the top level. No clearing pass is needed.
module four_level_page_table_walker_core #(
  parameter int PA_BITS = 52
) (
  input logic      clk,
  input logic      rst_n,
  fpw_in_if.sink   in_chan,
  fpw_out_if.source out_chan
);
  import fpw_pkg::*;

  fpw_cmd_t front_cmd;
  fpw_cmd_t queue_cmd;
  fpw_res_t back_res;
  logic     q_full;
  logic     q_not_empty;
  logic     q_pop;
  logic     q_push;

  // Front: classify and mask
  fpw_front #(
    .PA_BITS(PA_BITS)
  ) u_front (
    .req_type  (in_chan.req_type),
    .dir_base  (in_chan.dir_base),
    .virt_addr (in_chan.virt_addr),
    .entry_data(in_chan.entry_data),
    .read_error(in_chan.read_error),
    .cmd       (front_cmd)
  );

  assign in_chan.ready = !q_full;
  assign q_push        = in_chan.valid && !q_full;

  // Queue: decouple acceptance from result stalls
  fpw_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(front_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .not_empty(q_not_empty),
    .pop_data (queue_cmd)
  );

  // Back: advance the walk and register the result
  fpw_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_valid(q_not_empty),
    .cmd      (queue_cmd),
    .cmd_pop  (q_pop),
    .res_valid(out_chan.valid),
    .res_ready(out_chan.ready),
    .res      (back_res)
  );

  assign out_chan.out_kind    = back_res.out_kind;
  assign out_chan.read_addr   = back_res.read_addr;
  assign out_chan.phys_addr   = back_res.phys_addr;
  assign out_chan.fault       = back_res.fault;
  assign out_chan.fault_level = back_res.fault_level;
  assign out_chan.map_size    = back_res.map_size;

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// Testbench for four_level_page_table_walker_core: directed walks, then random walk traffic.
// Predicts every result from a local walker model and checks it field by field.
// Depends on fpw_pkg, fpw_in_if and fpw_out_if from the RTL.
module testbench;
  import fpw_pkg::*;

  localparam int PA_BITS      = 52;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE_CYCLES = 10;
  localparam int PHASE_ITEMS  = 380;

  // Physical frames and entry addresses are cut down to PA_BITS
  localparam logic [PA_W-1:0] PHYS_MASK = {PA_W{1'b1}} >> (PA_W - PA_BITS);

  // One input transaction, as the sender presents it
  typedef struct packed {
    logic               req_type;
    logic [PA_W-1:0]    dir_base;
    logic [VA_W-1:0]    virt_addr;
    logic [ENTRY_W-1:0] entry_data;
    logic               read_error;
  } walk_txn_t;

  logic clk;
  logic rst_n;

  fpw_in_if  in_chan();
  fpw_out_if out_chan();

  four_level_page_table_walker_core #(
    .PA_BITS(PA_BITS)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  // Local copy of the walker state, advanced at each accepted transaction
  logic               walk_busy;
  logic [LEVEL_W-1:0] walk_lvl;
  logic [VA_W-1:0]    walk_vaddr;
  logic [PA_W-1:0]    walk_table;

  fpw_res_t expected_results[$];
  int       error_count;
  int       send_idle_pct;
  int       recv_stall_pct;
  int       cycle_count;

  // Clock: 8 ns period
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Abort a hung run
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Result sink: stall at random according to the current phase
  initial begin
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Address of the entry for the current level: table base plus index times 8
  function automatic logic [PA_W-1:0] entry_read_addr();
    int              sh;
    logic [IDX_W-1:0] idx;
    sh  = 39 - 9 * int'(walk_lvl);
    idx = IDX_W'(walk_vaddr >> sh);
    return (walk_table + {idx, 3'b000}) & PHYS_MASK;
  endfunction

  // Advance the local walker by one accepted transaction and return its result
  function automatic fpw_res_t next_walk_result(input walk_txn_t t);
    fpw_res_t        r;
    logic [PA_W-1:0] frame;
    r = '0;
    r.out_kind = KIND_PERR;
    if (t.req_type == REQ_TRANSLATE) begin
      // A request while a walk runs leaves the walk untouched
      if (!walk_busy) begin
        walk_busy   = 1'b1;
        walk_lvl    = LVL_TOP;
        walk_vaddr  = t.virt_addr;
        walk_table  = t.dir_base & PHYS_MASK & ~{{(PA_W-12){1'b0}}, 12'hfff};
        r.out_kind  = KIND_READ;
        r.read_addr = entry_read_addr();
      end
    end else if (walk_busy) begin
      r.out_kind    = KIND_DONE;
      r.fault_level = walk_lvl;
      if (t.read_error || !t.entry_data[0]) begin
        // Failed read or entry not present: the rest of the entry is ignored
        r.fault = 1'b1;
      end else if (walk_lvl == LVL_1G && t.entry_data[7]) begin
        frame       = t.entry_data[PA_W-1:0] & PHYS_MASK & ~{{(PA_W-30){1'b0}}, 30'h3fffffff};
        r.phys_addr = frame + walk_vaddr[29:0];
        r.map_size  = PSZ_1G;
      end else if (walk_lvl == LVL_2M && t.entry_data[7]) begin
        frame       = t.entry_data[PA_W-1:0] & PHYS_MASK & ~{{(PA_W-21){1'b0}}, 21'h1fffff};
        r.phys_addr = frame + walk_vaddr[20:0];
        r.map_size  = PSZ_2M;
      end else if (walk_lvl == LVL_LEAF) begin
        // Bit 7 is the PAT bit here; only a zero 4KB frame faults
        frame = t.entry_data[PA_W-1:0] & PHYS_MASK & ~{{(PA_W-12){1'b0}}, 12'hfff};
        if (frame == '0) begin
          r.fault = 1'b1;
        end else begin
          r.phys_addr = frame + walk_vaddr[11:0];
          r.map_size  = PSZ_4K;
        end
      end else begin
        // Descend; the size bit at the top level is reserved and ignored
        walk_table    = t.entry_data[PA_W-1:0] & PHYS_MASK & ~{{(PA_W-12){1'b0}}, 12'hfff};
        walk_lvl      = walk_lvl + 1'b1;
        r.out_kind    = KIND_READ;
        r.fault_level = walk_lvl;
        r.read_addr   = entry_read_addr();
      end
      if (r.out_kind == KIND_DONE) begin
        walk_busy = 1'b0;
        walk_lvl  = LVL_TOP;
      end
    end
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic walk_txn_t translate_txn(input logic [PA_W-1:0] base,
                                              input logic [VA_W-1:0] va);
    walk_txn_t t;
    t            = '0;
    t.req_type   = REQ_TRANSLATE;
    t.dir_base   = base;
    t.virt_addr  = va;
    return t;
  endfunction

  function automatic walk_txn_t response_txn(input logic [ENTRY_W-1:0] entry,
                                             input logic rerr);
    walk_txn_t t;
    t            = '0;
    t.req_type   = REQ_RESPONSE;
    t.entry_data = entry;
    t.read_error = rerr;
    return t;
  endfunction

  // Present one transaction, hold it until accepted, then record its expected result.
  // Leave valid high afterwards so back-to-back transactions need no second assignment.
  task automatic send_txn(input walk_txn_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.req_type   <= t.req_type;
    in_chan.dir_base   <= t.dir_base;
    in_chan.virt_addr  <= t.virt_addr;
    in_chan.entry_data <= t.entry_data;
    in_chan.read_error <= t.read_error;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    expected_results.push_back(next_walk_result(t));
  endtask

  // Drop valid and hold off until every expected result has come back
  task automatic wait_drain();
    in_chan.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endtask

  // Result checker: compare each accepted result with the oldest expectation
  always @(posedge clk) begin : result_check
    fpw_res_t want;
    if (rst_n && out_chan.valid === 1'b1 && out_chan.ready) begin
      if (expected_results.size() == 0) begin
        $error("out_kind: expected no result, got 0x%0h", out_chan.out_kind);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("out_kind",    64'(want.out_kind),    64'(out_chan.out_kind));
        check_field("read_addr",   64'(want.read_addr),   64'(out_chan.read_addr));
        check_field("phys_addr",   64'(want.phys_addr),   64'(out_chan.phys_addr));
        check_field("fault",       64'(want.fault),       64'(out_chan.fault));
        check_field("fault_level", 64'(want.fault_level), 64'(out_chan.fault_level));
        check_field("map_size",    64'(want.map_size),    64'(out_chan.map_size));
      end
    end
  end

  // Response while idle, request while busy, then close the walk with a failed read
  task automatic test_protocol_errors();
    send_txn(response_txn('1, 1'b0));
    send_txn(translate_txn(52'h0_1234_5678_9000, 48'h1234_5678_9abc));
    send_txn(translate_txn('1, '1));
    send_txn(response_txn(64'h0, 1'b1));
  endtask

  // One walk for each page size, with the ignored size bits and zero large frames
  task automatic test_page_sizes();
    // 4KB walk with every bit set: size bit ignored at the top, PAT bit at the leaf
    send_txn(translate_txn('1, '1));
    send_txn(response_txn('1, 1'b0));
    send_txn(response_txn(64'hffff_ffff_ffff_ff7f, 1'b0));
    send_txn(response_txn(64'hffff_ffff_ffff_ff7f, 1'b0));
    send_txn(response_txn('1, 1'b0));
    // 1GB page with frame zero: no fault
    send_txn(translate_txn('0, '0));
    send_txn(response_txn(64'h1, 1'b0));
    send_txn(response_txn(64'h81, 1'b0));
    // 2MB page with frame zero: no fault
    send_txn(translate_txn(52'h8_0000_0000_0fff, 48'h8040_2010_0abc));
    send_txn(response_txn(64'h8000_0000_0000_3001, 1'b0));
    send_txn(response_txn(64'h0000_0001_2345_6003, 1'b0));
    send_txn(response_txn(64'h81, 1'b0));
  endtask

  // Faults: failed read with other bits set, missing entry, zero leaf frame
  task automatic test_faults();
    send_txn(translate_txn(52'h5_5555_5555_5000, 48'haaaa_aaaa_aaaa));
    send_txn(response_txn('1, 1'b1));
    send_txn(translate_txn(52'ha_aaaa_aaaa_a000, 48'h5555_5555_5555));
    send_txn(response_txn(64'h0000_000f_edcb_a001, 1'b0));
    send_txn(response_txn(64'hffff_ffff_ffff_fffe, 1'b0));
    send_txn(translate_txn(52'h0_0000_0001_0000, 48'h7fff_ffff_f000));
    send_txn(response_txn(64'h7, 1'b0));
    send_txn(response_txn(64'h2003, 1'b0));
    send_txn(response_txn(64'h3003, 1'b0));
    send_txn(response_txn(64'hfff0_0000_0000_0fff, 1'b0));
  endtask

  // Mostly complete walks with random content; the rest is noise that hits
  // responses while idle, requests while busy and random kinds
  task automatic test_random_traffic(input int n_items);
    int               sent;
    walk_txn_t        t;
    logic [ENTRY_W-1:0] e;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 80) begin
        send_txn(translate_txn(PA_W'(rand64()), VA_W'(rand64())));
        sent++;
        while (walk_busy) begin
          if ($urandom_range(29) == 0) begin
            t = translate_txn(PA_W'(rand64()), VA_W'(rand64()));
          end else begin
            e    = rand64();
            e[0] = ($urandom_range(11) != 0);
            if ($urandom_range(15) == 0) e[51:12] = '0;
            t = response_txn(e, $urandom_range(19) == 0);
          end
          send_txn(t);
          sent++;
        end
      end else begin
        t            = '0;
        t.req_type   = 1'($urandom_range(1));
        t.dir_base   = PA_W'(rand64());
        t.virt_addr  = VA_W'(rand64());
        t.entry_data = rand64();
        t.read_error = 1'($urandom_range(1));
        send_txn(t);
        sent++;
      end
    end
  endtask

  initial begin
    error_count    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    walk_busy      = 1'b0;
    walk_lvl       = LVL_TOP;
    walk_vaddr     = '0;
    walk_table     = '0;
    rst_n              <= 1'b0;
    in_chan.valid      <= 1'b0;
    in_chan.req_type   <= REQ_TRANSLATE;
    in_chan.dir_base   <= '0;
    in_chan.virt_addr  <= '0;
    in_chan.entry_data <= '0;
    in_chan.read_error <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_protocol_errors();
    test_page_sizes();
    test_faults();

    // Phases of sender idling and receiver stalls; drain between them so the sender sits out a full pause
    test_random_traffic(PHASE_ITEMS);
    wait_drain();
    send_idle_pct = 60;
    test_random_traffic(PHASE_ITEMS);
    wait_drain();
    send_idle_pct  = 0;
    recv_stall_pct = 60;
    test_random_traffic(PHASE_ITEMS);
    wait_drain();
    send_idle_pct  = 25;
    recv_stall_pct = 25;
    test_random_traffic(PHASE_ITEMS);
    wait_drain();

    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
